// File: src/oid_arcs_to_text_core_defines.svh
// Assertion macros for the OID arc-to-text core.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef OID_ARCS_TO_TEXT_CORE_DEFINES_SVH
`define OID_ARCS_TO_TEXT_CORE_DEFINES_SVH

// Property checked every clock, off while reset is low.
`define OID_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define OID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/oid_pkg.sv
// Shared types and constants of the OID arc-to-text core.
// No dependencies; used by the channel interfaces and the core.
package oid_pkg;

  localparam int unsigned ARC_W  = 64;  // arc field width on the input channel
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned CAP_W  = 9;

  localparam logic [CAP_W-1:0]  CAP_RESET = 9'd256;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;  // '.'

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_SMALL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_EMIT,
    S_TAIL
  } state_e;

  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  len;
    logic              eor;
  } txt_item_t;

endpackage

// File: src/oid_if.sv
// Valid/ready channel interfaces: arcs in, text items out.
// Depends on oid_pkg for field widths.
interface oid_arc_if;
  import oid_pkg::*;
  logic             valid;
  logic             ready;
  logic [ARC_W-1:0] arc_value;
  logic             last_arc;

  modport source (output valid, output arc_value, output last_arc, input ready);
  modport sink   (input valid, input arc_value, input last_arc, output ready);
endinterface

interface oid_txt_if;
  import oid_pkg::*;
  logic              valid;
  logic              ready;
  logic              out_kind;
  logic [CHAR_W-1:0] out_char;
  logic [STAT_W-1:0] status;
  logic [LEN_W-1:0]  text_length;
  logic              end_of_run;

  modport source (output valid, output out_kind, output out_char, output status,
                  output text_length, output end_of_run, input ready);
  modport sink   (input valid, input out_kind, input out_char, input status,
                  input text_length, input end_of_run, output ready);
endinterface

// File: src/oid_arcs_to_text_core.sv
// Per arc: an accept step in S_IDLE, ARC_BITS double-dabble shift steps in S_CONV, one step per
// BCD digit position in S_EMIT (NDIG; leading zeros skipped, digits held while the sink stalls),
// then one step for '.' or status in S_TAIL.
// No new arc is accepted until the last one has left S_TAIL; the shared shift/add-3 unit sets this.
// Reset (rst_ni low, async): idle, output empty, count cleared, capacity = 256.
module oid_arcs_to_text_core #(
  parameter int unsigned MAX_TEXT = 256,  // 16..4096
  parameter int unsigned ARC_BITS = 64    // 8..64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [oid_pkg::CAP_W-1:0]  cfg_wdata_i,
  oid_arc_if.sink                    arc_i,
  oid_txt_if.source                  txt_o
);
  import oid_pkg::*;
  `include "oid_arcs_to_text_core_defines.svh"

  // decimal digits of the largest arc: floor(ARC_BITS * log10(2)) + 1
  localparam int unsigned NDIG = (ARC_BITS * 30103) / 100000 + 1;
  localparam int unsigned BCDW = NDIG * 4;
  localparam int unsigned BITW = (ARC_BITS > 1) ? $clog2(ARC_BITS) : 1;
  localparam int unsigned RW   = $clog2(NDIG + 1);
  localparam int unsigned CW   = $clog2(MAX_TEXT + 1);
  localparam int unsigned CMPW = (CW + 1 > CAP_W) ? CW + 1 : CAP_W;

  state_e              st_q, st_d;
  logic [ARC_BITS-1:0] bin_q, bin_d;      // binary arc, shifted out MSB first
  logic [BCDW-1:0]     bcd_q, bcd_d;      // BCD accumulator, later the digit shifter
  logic [BITW-1:0]     bits_q, bits_d;    // shift steps left in conversion
  logic [RW-1:0]       rem_q, rem_d;      // digit positions left to emit
  logic                started_q, started_d;
  logic                last_q, last_d;
  logic [CW-1:0]       cnt_q, cnt_d;      // characters so far, saturating
  logic                seen_q, seen_d;    // too_long_seen
  logic [CAP_W-1:0]    cap_q;
  txt_item_t           item_q, item_d;
  logic                oval_q;
  logic                load;

  logic                out_free;
  logic [BCDW-1:0]     bcd_adj;
  logic [3:0]          top;
  logic [CW-1:0]       cnt_inc;
  logic                seen_inc;
  logic [CMPW-1:0]     need;

  assign out_free = !oval_q || txt_o.ready;
  assign top      = bcd_q[BCDW-1 -: 4];

  // add-3 correction on every digit lane ahead of the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // count after one more character; saturates at MAX_TEXT
  assign cnt_inc  = (cnt_q < CW'(MAX_TEXT)) ? cnt_q + CW'(1) : cnt_q;
  assign seen_inc = seen_q || (cnt_inc >= CW'(MAX_TEXT));
  assign need     = CMPW'(cnt_q) + CMPW'(1);  // text plus NUL

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      cap_q  <= CAP_RESET;
      oval_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load) begin
        oval_q <= 1'b1;
      end else if (txt_o.ready) begin
        oval_q <= 1'b0;
      end
    end
  end

  // datapath registers: no reset needed
  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    bcd_q     <= bcd_d;
    bits_q    <= bits_d;
    rem_q     <= rem_d;
    started_q <= started_d;
    last_q    <= last_d;
    if (load) begin
      item_q <= item_d;
    end
  end

  always_comb begin
    st_d        = st_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    bits_d      = bits_q;
    rem_d       = rem_q;
    started_d   = started_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    seen_d      = seen_q;
    load        = 1'b0;
    item_d      = '0;
    arc_i.ready = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        arc_i.ready = 1'b1;
        if (arc_i.valid) begin
          bin_d     = arc_i.arc_value[ARC_BITS-1:0];  // upper bits ignored
          bcd_d     = '0;
          bits_d    = BITW'(ARC_BITS - 1);
          rem_d     = RW'(NDIG);
          started_d = 1'b0;
          last_d    = arc_i.last_arc;
          st_d      = S_CONV;
        end
      end
      S_CONV: begin
        bcd_d = {bcd_adj[BCDW-2:0], bin_q[ARC_BITS-1]};
        bin_d = bin_q << 1;
        if (bits_q == '0) begin
          st_d = S_EMIT;
        end else begin
          bits_d = bits_q - BITW'(1);
        end
      end
      S_EMIT: begin
        if (!started_q && (top == 4'd0) && (rem_q > RW'(1))) begin
          // leading zero: drop it, keep at least one digit
          bcd_d = bcd_q << 4;
          rem_d = rem_q - RW'(1);
        end else if (out_free) begin
          load        = 1'b1;
          item_d.kind = KIND_CHAR;
          item_d.ch   = CHAR_ZERO | {4'd0, top};
          bcd_d       = bcd_q << 4;
          rem_d       = rem_q - RW'(1);
          started_d   = 1'b1;
          cnt_d       = cnt_inc;
          seen_d      = seen_inc;
          if (rem_q == RW'(1)) begin
            st_d = S_TAIL;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          load       = 1'b1;
          item_d.eor = 1'b1;
          if (!last_q) begin
            item_d.kind = KIND_CHAR;
            item_d.ch   = CHAR_DOT;
            cnt_d       = cnt_inc;
            seen_d      = seen_inc;
          end else begin
            item_d.kind = KIND_STATUS;
            if (seen_q || (cnt_q >= CW'(MAX_TEXT))) begin
              item_d.status = ST_TOO_LONG;
            end else if (CMPW'(cap_q) < need) begin
              item_d.status = ST_TOO_SMALL;
              item_d.len    = need[LEN_W-1:0];
            end else begin
              item_d.status = ST_OK;
              item_d.len    = LEN_W'(cnt_q);
            end
            cnt_d  = '0;  // next identifier starts fresh
            seen_d = 1'b0;
          end
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign txt_o.valid       = oval_q;
  assign txt_o.out_kind    = item_q.kind;
  assign txt_o.out_char    = item_q.ch;
  assign txt_o.status      = item_q.status;
  assign txt_o.text_length = item_q.len;
  assign txt_o.end_of_run  = item_q.eor;

  // an accepted arc keeps the input closed while it converts
  `OID_ASSERT_NEXT(a_busy_after_accept, arc_i.valid && arc_i.ready, !arc_i.ready,
    "input ready right after an accept")
  // a pending character item means the count has advanced
  `OID_ASSERT(a_char_counted, txt_o.valid && (txt_o.out_kind == KIND_CHAR) |-> cnt_q != '0,
    "character pending with zero count")
  // only the dot may close a run among character items
  `OID_ASSERT(a_eor_dot, txt_o.valid && txt_o.end_of_run && (txt_o.out_kind == KIND_CHAR)
    |-> txt_o.out_char == CHAR_DOT, "run ends on a digit")

endmodule
